// ----- hdl/koch_curve_segment_generator_core_macros.svh -----
// Assertion macros used by the Koch curve generator checker
`ifndef KOCH_CURVE_SEGMENT_GENERATOR_CORE_MACROS_SVH
`define KOCH_CURVE_SEGMENT_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define KCSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/kcsg_pkg.sv -----
// Types, constants and arithmetic helpers of the Koch curve segment generator
package kcsg_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int MAX_DEPTH   = 2;
  localparam int LEVELS      = MAX_DEPTH + 1;
  localparam int PTS         = 5;
  localparam int NPTS        = LEVELS * PTS;
  localparam int ADDR_W      = $clog2(NPTS);
  localparam int LVL_W       = 2;
  localparam int SEL_W       = $clog2(PTS);
  localparam int CALC_LAT    = 3;
  localparam int SEG_W       = 4 * COORD_WIDTH;

  localparam logic [LVL_W-1:0] DEPTH_RESET = LVL_W'(2);
  localparam logic [1:0]       CHILD_LAST  = 2'd3;

  // arithmetic widths
  localparam int SUM_W   = COORD_WIDTH + 2;
  localparam int MAG_W   = COORD_WIDTH + 1;
  localparam int RCP_W   = 16;
  localparam int PROD3_W = MAG_W + RCP_W;
  localparam int DX_W    = COORD_WIDTH + 1;
  localparam int MUL_W   = 2 * DX_W;
  localparam int Q_SHIFT = 16;
  localparam int ACC_W   = MUL_W + 2;
  localparam int TR_W    = ACC_W - Q_SHIFT;

  // 1/3 as 43691 / 2^17, exact for magnitudes below 2^17
  localparam logic [RCP_W-1:0] DIV3_RECIP = 16'd43691;
  localparam int               DIV3_SHIFT = 17;

  localparam logic signed [DX_W-1:0] COS_Q16 = 17'sd32798;
  localparam logic signed [DX_W-1:0] SIN_Q16 = 17'sd56738;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}});

  typedef struct packed {
    coord_t y;
    coord_t x;
  } kcsg_pt_t;

  typedef struct packed {
    logic [LVL_W-1:0] depth;
    kcsg_pt_t         b;
    kcsg_pt_t         a;
  } kcsg_item_t;

  typedef struct packed {
    kcsg_pt_t e;
    kcsg_pt_t s;
  } kcsg_seg_t;

  typedef struct packed {
    kcsg_pt_t p3;
    kcsg_pt_t p2;
    kcsg_pt_t p1;
  } kcsg_split_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_WR,
    ST_FETCH,
    ST_LOAD,
    ST_EMIT_RD,
    ST_EMIT,
    ST_NEXT
  } kcsg_state_e;

  // signed division by three, truncated toward zero
  function automatic coord_t div3(input logic signed [SUM_W-1:0] v);
    logic [MAG_W-1:0]   mag;
    logic [PROD3_W-1:0] prod;
    logic [MAG_W-1:0]   q;
    mag  = v[SUM_W-1] ? MAG_W'(-v) : MAG_W'(v);
    prod = PROD3_W'(mag) * PROD3_W'(DIV3_RECIP);
    q    = MAG_W'(prod >> DIV3_SHIFT);
    if (v[SUM_W-1]) begin
      q = ~q + MAG_W'(1);
    end
    return coord_t'(q[COORD_WIDTH-1:0]);
  endfunction

  // Q16 accumulator to coordinate: truncate toward zero, then saturate
  function automatic coord_t trunc_sat(input logic signed [ACC_W-1:0] acc);
    logic [TR_W-1:0] t;
    logic            ovf;
    t = acc[ACC_W-1:Q_SHIFT];
    if (acc[ACC_W-1] && (acc[Q_SHIFT-1:0] != '0)) begin
      t = t + TR_W'(1);
    end
    ovf = (t[TR_W-1:COORD_WIDTH-1] != '0) && (t[TR_W-1:COORD_WIDTH-1] != '1);
    if (ovf) begin
      return t[TR_W-1] ? COORD_MIN : COORD_MAX;
    end
    return coord_t'(t[COORD_WIDTH-1:0]);
  endfunction

  function automatic logic [ADDR_W-1:0] pt_addr(input logic [LVL_W-1:0] lvl,
                                                input logic [SEL_W-1:0] sel);
    return ADDR_W'(lvl) * ADDR_W'(PTS) + ADDR_W'(sel);
  endfunction

endpackage

// ----- hdl/kcsg_fifo.sv -----
// Small register queue of accepted segments between front and back end
module kcsg_fifo
  import kcsg_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  kcsg_item_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output kcsg_item_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kcsg_item_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/kcsg_front.sv -----
// Front end: depth register, input acceptance and queueing of segments
module kcsg_front
  import kcsg_pkg::*;
#(
  parameter int FIFO_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LVL_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SEG_W-1:0] in_data_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output kcsg_item_t       item_o
);

  logic [LVL_W-1:0] depth_q;
  logic [LVL_W-1:0] eff_depth;
  kcsg_item_t       item_in;
  logic             full, empty, push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RESET;
    end else if (cfg_valid_i) begin
      depth_q <= cfg_data_i;
    end
  end

  // depth above the supported maximum clamps
  assign eff_depth = (depth_q > LVL_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH) : depth_q;

  always_comb begin
    item_in.a     = kcsg_pt_t'(in_data_i[2*COORD_WIDTH-1:0]);
    item_in.b     = kcsg_pt_t'(in_data_i[4*COORD_WIDTH-1:2*COORD_WIDTH]);
    item_in.depth = eff_depth;
  end

  assign in_ready_o   = !full;
  assign push         = in_valid_i && !full;
  assign item_valid_o = !empty;
  assign pop          = item_ready_i && !empty;

  kcsg_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (item_o)
  );

endmodule

// ----- hdl/kcsg_ram.sv -----
// Generic RAM, one write port and two registered read ports
module kcsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- hdl/kcsg_calc.sv -----
// Three-stage split unit: third points, rotation products, apex
module kcsg_calc
  import kcsg_pkg::*;
(
  input  logic        clk_i,
  input  kcsg_pt_t    a_i,
  input  kcsg_pt_t    b_i,
  output kcsg_split_t res_o
);

  logic signed [SUM_W-1:0] s1x, s1y, s3x, s3y;
  kcsg_pt_t                p1_q, p3_q, p1h_q, p2_q;
  logic signed [DX_W-1:0]  dx, dy;
  logic signed [MUL_W-1:0] cx_q, cy_q, sx_q, sy_q;
  logic signed [ACC_W-1:0] acc_x, acc_y;

  // stage 1: (2A+B)/3 and (A+2B)/3
  assign s1x = (SUM_W'(a_i.x) <<< 1) + SUM_W'(b_i.x);
  assign s1y = (SUM_W'(a_i.y) <<< 1) + SUM_W'(b_i.y);
  assign s3x = SUM_W'(a_i.x) + (SUM_W'(b_i.x) <<< 1);
  assign s3y = SUM_W'(a_i.y) + (SUM_W'(b_i.y) <<< 1);

  always_ff @(posedge clk_i) begin
    p1_q.x <= div3(s1x);
    p1_q.y <= div3(s1y);
    p3_q.x <= div3(s3x);
    p3_q.y <= div3(s3y);
  end

  // stage 2: rotation products
  assign dx = DX_W'(p3_q.x) - DX_W'(p1_q.x);
  assign dy = DX_W'(p3_q.y) - DX_W'(p1_q.y);

  always_ff @(posedge clk_i) begin
    cx_q  <= MUL_W'(dx) * MUL_W'(COS_Q16);
    cy_q  <= MUL_W'(dy) * MUL_W'(COS_Q16);
    sx_q  <= MUL_W'(dx) * MUL_W'(SIN_Q16);
    sy_q  <= MUL_W'(dy) * MUL_W'(SIN_Q16);
    p1h_q <= p1_q;
  end

  // stage 3: accumulate, truncate, saturate
  assign acc_x = (ACC_W'(p1h_q.x) <<< Q_SHIFT) + ACC_W'(cx_q) + ACC_W'(sy_q);
  assign acc_y = (ACC_W'(p1h_q.y) <<< Q_SHIFT) - ACC_W'(sx_q) + ACC_W'(cy_q);

  always_ff @(posedge clk_i) begin
    p2_q.x <= trunc_sat(acc_x);
    p2_q.y <= trunc_sat(acc_y);
  end

  assign res_o.p1 = p1_q;
  assign res_o.p2 = p2_q;
  assign res_o.p3 = p3_q;

endmodule

// ----- hdl/kcsg_back.sv -----
// Back end: depth-first expansion sequencer, point store and output register
module kcsg_back
  import kcsg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  kcsg_item_t item_i,
  output logic       seg_valid_o,
  input  logic       seg_ready_i,
  output kcsg_seg_t  seg_o,
  output logic       seg_last_o
);

  kcsg_state_e                  state_q, state_d;
  kcsg_pt_t                     a_q, a_d, b_q, b_d;
  logic [LVL_W-1:0]             d_q, d_d;
  logic [LVL_W-1:0]             lvl_q, lvl_d;
  logic [LVL_W-1:0]             wlvl_q, wlvl_d;
  logic [SEL_W-1:0]             cnt_q, cnt_d;
  logic [LEVELS-1:0][1:0]       child_q, child_d;
  logic                         out_valid_q, out_valid_d;
  kcsg_seg_t                    out_seg_q, out_seg_d;
  logic                         out_last_q, out_last_d;

  kcsg_split_t                  split;
  logic                         we;
  logic [ADDR_W-1:0]            waddr, raddr_a, raddr_b;
  kcsg_pt_t                     wdata, rdata_a, rdata_b;

  logic                         child_end, calc_done, wr_done, emit_fire, last_c;

  assign child_end = (child_q[lvl_q] == CHILD_LAST);
  assign calc_done = (cnt_q == SEL_W'(CALC_LAT - 1));
  assign wr_done   = (cnt_q == SEL_W'(PTS - 1));
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || seg_ready_i);

  assign raddr_a = pt_addr(lvl_q, SEL_W'(child_q[lvl_q]));
  assign raddr_b = pt_addr(lvl_q, SEL_W'(child_q[lvl_q]) + SEL_W'(1));
  assign waddr   = pt_addr(wlvl_q, cnt_q);

  always_comb begin
    case (cnt_q)
      SEL_W'(0): wdata = a_q;
      SEL_W'(1): wdata = split.p1;
      SEL_W'(2): wdata = split.p2;
      SEL_W'(3): wdata = split.p3;
      default:   wdata = b_q;
    endcase
  end

  // final segment of the curve: every open level on its last child
  always_comb begin
    last_c = 1'b1;
    for (int i = 0; i < LEVELS; i++) begin
      if ((LVL_W'(i) <= lvl_q) && (child_q[i] != CHILD_LAST)) begin
        last_c = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (item_valid_i) state_d = ST_CALC;
      ST_CALC:    if (calc_done) state_d = ST_WR;
      ST_WR: begin
        if (wr_done) begin
          state_d = (wlvl_q == d_q) ? ST_EMIT_RD : ST_FETCH;
        end
      end
      ST_FETCH:   state_d = ST_LOAD;
      ST_LOAD:    state_d = ST_CALC;
      ST_EMIT_RD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire) begin
          if (!child_end) begin
            state_d = ST_EMIT_RD;
          end else if (lvl_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (!child_end) begin
          state_d = ST_FETCH;
        end else if (lvl_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    a_d          = a_q;
    b_d          = b_q;
    d_d          = d_q;
    lvl_d        = lvl_q;
    wlvl_d       = wlvl_q;
    cnt_d        = cnt_q;
    child_d      = child_q;
    out_valid_d  = out_valid_q && !seg_ready_i;
    out_seg_d    = out_seg_q;
    out_last_d   = out_last_q;
    we           = 1'b0;
    item_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          a_d    = item_i.a;
          b_d    = item_i.b;
          d_d    = item_i.depth;
          wlvl_d = '0;
          cnt_d  = '0;
        end
      end
      ST_CALC: begin
        cnt_d = calc_done ? '0 : cnt_q + SEL_W'(1);
      end
      ST_WR: begin
        we    = 1'b1;
        cnt_d = cnt_q + SEL_W'(1);
        if (wr_done) begin
          cnt_d           = '0;
          lvl_d           = wlvl_q;
          child_d[wlvl_q] = '0;
        end
      end
      ST_FETCH: begin
        wlvl_d = lvl_q + LVL_W'(1);
      end
      ST_LOAD: begin
        a_d   = rdata_a;
        b_d   = rdata_b;
        cnt_d = '0;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          out_seg_d.s = rdata_a;
          out_seg_d.e = rdata_b;
          out_last_d  = last_c;
          if (!child_end) begin
            child_d[lvl_q] = child_q[lvl_q] + 2'd1;
          end else if (lvl_q != '0) begin
            lvl_d = lvl_q - LVL_W'(1);
          end
        end
      end
      ST_NEXT: begin
        if (!child_end) begin
          child_d[lvl_q] = child_q[lvl_q] + 2'd1;
        end else if (lvl_q != '0) begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      d_q         <= '0;
      lvl_q       <= '0;
      wlvl_q      <= '0;
      cnt_q       <= '0;
      child_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      d_q         <= d_d;
      lvl_q       <= lvl_d;
      wlvl_q      <= wlvl_d;
      cnt_q       <= cnt_d;
      child_q     <= child_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    out_seg_q  <= out_seg_d;
    out_last_q <= out_last_d;
  end

  assign seg_valid_o = out_valid_q;
  assign seg_o       = out_seg_q;
  assign seg_last_o  = out_last_q;

  kcsg_calc u_calc (
    .clk_i (clk_i),
    .a_i   (a_q),
    .b_i   (b_q),
    .res_o (split)
  );

  // point store: five points per level, x in the low half
  kcsg_ram #(
    .WIDTH ($bits(kcsg_pt_t)),
    .DEPTH (NPTS)
  ) u_points (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

endmodule

// ----- hdl/koch_curve_segment_generator_core.sv -----
// Koch curve segment generator top level: front end, queue and expansion back end
//
//  channel  direction  beat carries
//  cfg      in         depth (2 bits), no address
//  s_axis   in         one segment: start and end point
//  m_axis   out        one curve segment, tlast on the final one of a curve
//
// A curve of depth d gives 4^(d+1) segments; every split passes through the
// three-stage split unit and the single write port of the point store, and the
// sequencer takes the next item only after it has issued the curve's final segment.
// Reset is asynchronous, active low; depth resets to 2.
// Up to FIFO_DEPTH segments queue in front while one curve is expanded; a stall
// on m_axis holds the sequencer, not the input side, until the queue fills.
module koch_curve_segment_generator_core
  import kcsg_pkg::*;
#(
  parameter int FIFO_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LVL_W-1:0] cfg_data_i,     // depth
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [SEG_W-1:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [SEG_W-1:0] m_axis_tdata,   // seg_start_x, seg_start_y, seg_end_x, seg_end_y
  output logic             m_axis_tlast
);

  logic       item_valid, item_ready;
  kcsg_item_t item;
  kcsg_seg_t  seg;

  kcsg_front #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  kcsg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .seg_valid_o  (m_axis_tvalid),
    .seg_ready_i  (m_axis_tready),
    .seg_o        (seg),
    .seg_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = seg;

endmodule

// ----- hdl/kcsg_checker.sv -----
// Port-level checker for the Koch curve segment generator, bound to the top level
`include "koch_curve_segment_generator_core_macros.svh"

module kcsg_checker
  import kcsg_pkg::*;
#(
  parameter int FIFO_DEPTH = 2
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [SEG_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // queue, curve in expansion, and a last beat still waiting
  localparam int MAX_PEND = FIFO_DEPTH + 2;
  localparam int PEND_W   = $clog2(MAX_PEND + 1);

  logic [PEND_W-1:0] pend_q, pend_d;
  logic              in_beat, last_beat;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign last_beat = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  always_comb begin
    pend_d = pend_q;
    case ({in_beat, last_beat})
      2'b10:   pend_d = pend_q + PEND_W'(1);
      2'b01:   pend_d = pend_q - PEND_W'(1);
      default: pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `KCSG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")
  `KCSG_ASSERT_NOW(a_no_orphan, m_axis_tvalid, pend_q != '0, "output beat without an open curve")
  `KCSG_ASSERT_NOW(a_backlog, pend_q == PEND_W'(MAX_PEND), !s_axis_tready, "input taken beyond the backlog limit")

endmodule

bind koch_curve_segment_generator_core kcsg_checker #(
  .FIFO_DEPTH (FIFO_DEPTH)
) u_kcsg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
